// ===== hw/rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for differential drive odometry
// Item structs, sequencer states, fixed-point constants and the CORDIC
// arctangent table in binary-angle units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_IW    = $clog2(CORDIC_STEPS);

  localparam int MAC_AW     = 96;
  localparam int MAC_BW     = 32;
  localparam int MAC_PW     = MAC_AW + MAC_BW;
  localparam int MAC_CHUNKS = MAC_AW / MAC_BW;
  localparam int MAC_CW     = $clog2(MAC_CHUNKS);

  localparam int DIV_NW = 96;
  localparam int DIV_DW = 32;
  localparam int DIV_CW = $clog2(DIV_NW);

  localparam int CS_W = 34;  // CORDIC datapath width

  localparam logic [31:0] ANG_PER_RAD_TURN = 32'd683565276;
  localparam logic [31:0] GAIN_START       = 32'd652032874;
  localparam logic [31:0] VEL_SCALE        = 32'd1000;
  localparam logic [31:0] DPC_RESET        = 32'd2595000;
  localparam logic [23:0] TRACK_RESET      = 24'd38400;

  typedef enum logic {
    CFG_DIST_PER_COUNT = 1'b0,
    CFG_TRACK_WIDTH    = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic              command;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [31:0]       reset_epoch;
    logic [31:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] forward_pos;
    logic signed [47:0] lateral_pos;
    logic signed [31:0] heading;
    logic signed [31:0] linear_velocity;
    logic signed [47:0] angular_velocity;
    logic signed [31:0] latched_left;
    logic signed [31:0] latched_right;
    logic [31:0]        latched_epoch;
    logic               initialized;
    logic               finite;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIST_L,
    ST_DIST_R,
    ST_TURN_MUL,
    ST_TURN_DIV,
    ST_CORDIC,
    ST_FWD,
    ST_LAT,
    ST_POSE,
    ST_LIN_MUL,
    ST_LIN_DIV,
    ST_ANG_MUL,
    ST_ANG_DIV,
    ST_DONE
  } seq_state_t;

  function automatic logic [31:0] atan_angle(input logic [4:0] idx);
    logic [31:0] a;
    unique case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      5'd31: a = 32'h00000000;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/ddo_mac.sv =====
// ----------------------------------------------------------------------------
// ddo_mac: chunked multiplier
// Multiplies a 96-bit operand by a 32-bit operand one 32-bit chunk per cycle
// through a single 32x32 multiplier, most significant chunk first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ddo_pkg::MAC_AW-1:0]  a,
  input  logic [ddo_pkg::MAC_BW-1:0]  b,
  output logic                        done,
  output logic [ddo_pkg::MAC_PW-1:0]  p
);
  import ddo_pkg::*;

  logic [MAC_AW-1:0] a_r;
  logic [MAC_BW-1:0] b_r;
  logic [MAC_PW-1:0] p_r;
  logic [MAC_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [2*MAC_BW-1:0] part;

  assign part = (2*MAC_BW)'(a_r[MAC_AW-1 -: MAC_BW]) * (2*MAC_BW)'(b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == MAC_CW'(MAC_CHUNKS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= (p_r << MAC_BW) + MAC_PW'(part);
      a_r <= a_r << MAC_BW;
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ===== hw/rtl/ddo_div.sv =====
// ----------------------------------------------------------------------------
// ddo_div: restoring divider with round-half-up quotient
// One quotient bit per cycle; the quotient rounds up when twice the
// remainder reaches the divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ddo_pkg::DIV_NW-1:0]  n,
  input  logic [ddo_pkg::DIV_DW-1:0]  d,
  output logic                        done,
  output logic [ddo_pkg::DIV_NW-1:0]  q
);
  import ddo_pkg::*;

  logic [DIV_NW-1:0] n_r;
  logic [DIV_DW-1:0] d_r;
  logic [DIV_DW-1:0] r_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   r_sh;
  logic              ge;
  logic              rnd;

  assign r_sh = {r_r, n_r[DIV_NW-1]};
  assign ge   = (r_sh >= {1'b0, d_r});
  assign rnd  = ({r_r, 1'b0} >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= n;
      d_r <= d;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= ge ? DIV_DW'(r_sh - {1'b0, d_r}) : r_sh[DIV_DW-1:0];
      n_r <= {n_r[DIV_NW-2:0], ge};
    end
  end

  assign done = done_r;
  assign q    = n_r + DIV_NW'(rnd);

endmodule

// ===== hw/rtl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic: iterative CORDIC sine and cosine
// Folds the angle by half a turn into the right half plane, then runs one
// rotation step per cycle in Q30.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [31:0]                      angle,
  output logic                             done,
  output logic signed [ddo_pkg::CS_W-1:0]  cos_val,
  output logic signed [ddo_pkg::CS_W-1:0]  sin_val
);
  import ddo_pkg::*;

  logic signed [CS_W-1:0] x_r, y_r, z_r;
  logic signed [CS_W-1:0] dx, dy;
  logic [CS_W-1:0]        at;
  logic [CORDIC_IW-1:0]   cnt_r;
  logic                   busy_r;
  logic                   done_r;
  logic                   flip_r;
  logic                   flip;
  logic [31:0]            ang_f;

  assign flip  = angle[31] ^ angle[30];
  assign ang_f = flip ? (angle ^ 32'h8000_0000) : angle;
  assign dx    = y_r >>> cnt_r;
  assign dy    = x_r >>> cnt_r;
  assign at    = CS_W'(atan_angle(5'(cnt_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CORDIC_IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      x_r    <= CS_W'(GAIN_START);
      y_r    <= '0;
      z_r    <= {{(CS_W-32){ang_f[31]}}, ang_f};
    end else if (busy_r) begin
      // rotate toward zero residual angle
      if (!z_r[CS_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - signed'(at);
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + signed'(at);
      end
    end
  end

  assign done    = done_r;
  assign cos_val = flip_r ? -x_r : x_r;
  assign sin_val = flip_r ? -y_r : y_r;

endmodule

// ===== hw/rtl/differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry: wheel odometry with midpoint heading
// Integrates pose from encoder counts with CORDIC sine/cosine at the
// midpoint heading and derives linear and angular velocity.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    in_data   (in_item_t)
//  out      output     out_valid/out_ready  out_data  (out_item_t)
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  A reset command or first item goes from decode straight to done. An update
//  launches the shared unit in each multiply, divide and CORDIC state and
//  waits for its done: wheel distances, turn multiply and divide, CORDIC,
//  forward and lateral terms and the pose write, then the linear and angular
//  velocity multiply and divide, which are skipped on an epoch change or zero
//  elapsed time; the divider dominates. The sequencer returns to idle before
//  the next item is taken.
//  rst_n is synchronous; it restores the register defaults and zeroes the pose.
//  in_ready and cfg_ready are high only when the sequencer is idle; a finished
//  snapshot waits in the output register while the next item is taken, and
//  the done state holds while that register is still full and out_ready is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module differential_drive_odometry (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ddo_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ddo_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ddo_pkg::cfg_index_t cfg_index,
  input  logic [31:0]         cfg_data
);
  import ddo_pkg::*;

  localparam logic signed [52:0] MAX48 = 53'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [52:0] MIN48 = -53'sh0_8000_0000_0000;

  // saturating 48-bit add: {overflow, value}
  function automatic logic [48:0] sat_add(input logic signed [47:0] acc,
                                          input logic signed [51:0] t);
    logic signed [52:0] s;
    s = {{5{acc[47]}}, acc} + {t[51], t};
    if (s > MAX48) return {1'b1, MAX48[47:0]};
    if (s < MIN48) return {1'b1, MIN48[47:0]};
    return {1'b0, s[47:0]};
  endfunction

  // sequencer and unit handshakes
  seq_state_t state_r, state_nxt;
  logic       issued_r, issued_nxt;
  logic       mac_start, mac_done;
  logic       div_start, div_done;
  logic       cor_start, cor_done;
  logic [MAC_AW-1:0] mac_a;
  logic [MAC_BW-1:0] mac_b;
  logic [MAC_PW-1:0] mac_p;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;
  logic signed [CS_W-1:0] cos_val, sin_val;
  logic [31:0]       cor_angle;

  // configuration
  logic [31:0] dpc_r;
  logic [23:0] track_r;

  // architected state
  logic signed [47:0] fwd_acc_r, lat_acc_r, ang_vel_r;
  logic [31:0]        heading_r;
  logic signed [31:0] lin_vel_r, prev_left_r, prev_right_r;
  logic [31:0]        prev_epoch_r, prev_time_r;
  logic               init_r, finite_r;

  // working registers
  in_item_t           in_r;
  logic signed [32:0] dl_r, dr_r;
  logic [31:0]        elapsed_r;
  logic               velzero_r;
  logic signed [49:0] dist_l_r, dist_r_r;
  logic [48:0]        cm_r;
  logic               cneg_r, diffneg_r;
  logic [DIV_NW-1:0]  q_r;
  logic signed [51:0] term_r;
  out_item_t          out_r;
  logic               out_valid_r;

  // combinational helpers
  logic               reset_path;
  logic               epoch_chg;
  logic signed [32:0] dl_w, dr_w;
  logic [31:0]        elapsed_w;
  logic [32:0]        dl_mag, dr_mag;
  logic [48:0]        dist_mag;
  logic signed [49:0] dist_w;
  logic signed [50:0] sum_w, diff_w;
  logic [49:0]        sum_mag, diff_mag;
  logic [32:0]        qm;
  logic [31:0]        cos_mag, sin_mag;
  logic [50:0]        term_mag;
  logic signed [51:0] term_w;
  logic [48:0]        fwd_sat, lat_sat;
  logic [31:0]        track_div;
  logic [DIV_NW-1:0]  lin_lim, ang_lim;
  logic               lin_ovf, ang_ovf;
  logic [31:0]        lin_mag;
  logic [47:0]        ang_mag;

  assign reset_path = in_r.command || !init_r;
  assign epoch_chg  = (in_r.reset_epoch != prev_epoch_r);
  assign dl_w = epoch_chg ? {in_r.left_count[31], in_r.left_count}
              : {in_r.left_count[31], in_r.left_count} - {prev_left_r[31], prev_left_r};
  assign dr_w = epoch_chg ? {in_r.right_count[31], in_r.right_count}
              : {in_r.right_count[31], in_r.right_count} - {prev_right_r[31], prev_right_r};
  assign elapsed_w = in_r.now_ms - prev_time_r;

  assign dl_mag = dl_r[32] ? 33'(-dl_r) : 33'(dl_r);
  assign dr_mag = dr_r[32] ? 33'(-dr_r) : 33'(dr_r);

  // distance = magnitude * dpc / 2^16, rounded half away
  assign dist_mag = 49'(mac_p[63:16]) + 49'(mac_p[15]);
  assign dist_w   = ((state_r == ST_DIST_L) ? dl_r[32] : dr_r[32])
                  ? -$signed({1'b0, dist_mag}) : $signed({1'b0, dist_mag});

  assign sum_w    = {dist_l_r[49], dist_l_r} + {dist_r_r[49], dist_r_r};
  assign diff_w   = {dist_r_r[49], dist_r_r} - {dist_l_r[49], dist_l_r};
  assign sum_mag  = sum_w[50] ? 50'(-sum_w) : 50'(sum_w);
  assign diff_mag = diff_w[50] ? 50'(-diff_w) : 50'(diff_w);

  // low bits of the signed heading increment
  assign qm        = diffneg_r ? 33'(33'd0 - q_r[32:0]) : q_r[32:0];
  assign cor_angle = heading_r + qm[32:1];

  assign cos_mag = cos_val[CS_W-1] ? 32'(-cos_val) : 32'(cos_val);
  assign sin_mag = sin_val[CS_W-1] ? 32'(-sin_val) : 32'(sin_val);

  // pose term = cm * |trig| / 2^30, rounded half away
  assign term_mag = 51'(mac_p[80:30]) + 51'(mac_p[29]);
  assign term_w = (cneg_r ^ ((state_r == ST_FWD) ? cos_val[CS_W-1] : sin_val[CS_W-1]))
                ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});

  assign fwd_sat = sat_add(fwd_acc_r, term_r);
  assign lat_sat = sat_add(lat_acc_r, term_r);

  assign track_div = (track_r == 24'd0) ? 32'd1 : {8'd0, track_r};

  assign lin_lim = cneg_r ? DIV_NW'(33'h0_8000_0000) : DIV_NW'(33'h0_7FFF_FFFF);
  assign ang_lim = diffneg_r ? DIV_NW'(49'h0_8000_0000_0000)
                             : DIV_NW'(49'h0_7FFF_FFFF_FFFF);
  assign lin_ovf = (div_q > lin_lim);
  assign ang_ovf = (div_q > ang_lim);
  assign lin_mag = lin_ovf ? lin_lim[31:0] : div_q[31:0];
  assign ang_mag = ang_ovf ? ang_lim[47:0] : div_q[47:0];

  // shared arithmetic units
  ddo_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a     (mac_a),
    .b     (mac_b),
    .done  (mac_done),
    .p     (mac_p)
  );

  ddo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cor_start),
    .angle   (cor_angle),
    .done    (cor_done),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    mac_start  = 1'b0;
    div_start  = 1'b0;
    cor_start  = 1'b0;
    mac_a      = '0;
    mac_b      = '0;
    div_n      = mac_p[DIV_NW-1:0];
    div_d      = elapsed_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECODE;
      end
      ST_DECODE: begin
        state_nxt = reset_path ? ST_DONE : ST_DIST_L;
      end
      ST_DIST_L, ST_DIST_R, ST_TURN_MUL, ST_FWD, ST_LAT, ST_LIN_MUL, ST_ANG_MUL: begin
        priority case (state_r)
          ST_DIST_L:   begin mac_a = MAC_AW'(dl_mag);   mac_b = dpc_r; end
          ST_DIST_R:   begin mac_a = MAC_AW'(dr_mag);   mac_b = dpc_r; end
          ST_TURN_MUL: begin mac_a = MAC_AW'(diff_mag); mac_b = ANG_PER_RAD_TURN; end
          ST_FWD:      begin mac_a = MAC_AW'(cm_r);     mac_b = cos_mag; end
          ST_LAT:      begin mac_a = MAC_AW'(cm_r);     mac_b = sin_mag; end
          ST_LIN_MUL:  begin mac_a = MAC_AW'(cm_r);     mac_b = VEL_SCALE; end
          default:     begin mac_a = q_r;               mac_b = VEL_SCALE; end
        endcase
        mac_start = !issued_r;
        if (mac_done) begin
          issued_nxt = 1'b0;
          priority case (state_r)
            ST_DIST_L:   state_nxt = ST_DIST_R;
            ST_DIST_R:   state_nxt = ST_TURN_MUL;
            ST_TURN_MUL: state_nxt = ST_TURN_DIV;
            ST_FWD:      state_nxt = ST_LAT;
            ST_LAT:      state_nxt = ST_POSE;
            ST_LIN_MUL:  state_nxt = ST_LIN_DIV;
            default:     state_nxt = ST_ANG_DIV;
          endcase
        end else begin
          issued_nxt = 1'b1;
        end
      end
      ST_TURN_DIV, ST_LIN_DIV, ST_ANG_DIV: begin
        div_d     = (state_r == ST_TURN_DIV) ? track_div : elapsed_r;
        div_start = !issued_r;
        if (div_done) begin
          issued_nxt = 1'b0;
          priority case (state_r)
            ST_TURN_DIV: state_nxt = ST_CORDIC;
            ST_LIN_DIV:  state_nxt = ST_ANG_MUL;
            default:     state_nxt = ST_DONE;
          endcase
        end else begin
          issued_nxt = 1'b1;
        end
      end
      ST_CORDIC: begin
        cor_start = !issued_r;
        if (cor_done) begin
          issued_nxt = 1'b0;
          state_nxt  = ST_FWD;
        end else begin
          issued_nxt = 1'b1;
        end
      end
      ST_POSE: begin
        state_nxt = velzero_r ? ST_DONE : ST_LIN_MUL;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt  = ST_IDLE;
        issued_nxt = 1'b0;
      end
    endcase
  end

  // architected state, configuration and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpc_r        <= DPC_RESET;
      track_r      <= TRACK_RESET;
      fwd_acc_r    <= '0;
      lat_acc_r    <= '0;
      heading_r    <= '0;
      lin_vel_r    <= '0;
      ang_vel_r    <= '0;
      prev_left_r  <= '0;
      prev_right_r <= '0;
      prev_epoch_r <= '0;
      prev_time_r  <= '0;
      init_r       <= 1'b0;
      finite_r     <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DIST_PER_COUNT: dpc_r   <= cfg_data;
          CFG_TRACK_WIDTH:    track_r <= cfg_data[23:0];
          default:            dpc_r   <= dpc_r;
        endcase
      end

      if (state_r == ST_DECODE) begin
        prev_left_r  <= in_r.left_count;
        prev_right_r <= in_r.right_count;
        prev_time_r  <= in_r.now_ms;
        if (reset_path) begin
          // zero pose and velocity, restart the flags
          fwd_acc_r    <= '0;
          lat_acc_r    <= '0;
          heading_r    <= '0;
          lin_vel_r    <= '0;
          ang_vel_r    <= '0;
          prev_epoch_r <= in_r.reset_epoch;
          init_r       <= 1'b1;
          finite_r     <= 1'b1;
        end else if (epoch_chg) begin
          prev_epoch_r <= in_r.reset_epoch;
        end
      end

      // apply forward term while the lateral product runs
      if (state_r == ST_LAT && !issued_r) begin
        fwd_acc_r <= fwd_sat[47:0];
        if (fwd_sat[48]) finite_r <= 1'b0;
      end

      if (state_r == ST_POSE) begin
        lat_acc_r <= lat_sat[47:0];
        if (lat_sat[48]) finite_r <= 1'b0;
        heading_r <= heading_r + qm[31:0];
        if (velzero_r) begin
          lin_vel_r <= '0;
          ang_vel_r <= '0;
        end
      end

      if (state_r == ST_LIN_DIV && div_done) begin
        lin_vel_r <= cneg_r ? -$signed(lin_mag) : $signed(lin_mag);
        if (lin_ovf) finite_r <= 1'b0;
      end

      if (state_r == ST_ANG_DIV && div_done) begin
        ang_vel_r <= diffneg_r ? -$signed(ang_mag) : $signed(ang_mag);
        if (ang_ovf) finite_r <= 1'b0;
      end

      if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;

    if (state_r == ST_DECODE) begin
      dl_r      <= dl_w;
      dr_r      <= dr_w;
      elapsed_r <= elapsed_w;
      velzero_r <= epoch_chg || (elapsed_w == 32'd0);
    end

    if (state_r == ST_DIST_L && mac_done) dist_l_r <= dist_w;
    if (state_r == ST_DIST_R && mac_done) dist_r_r <= dist_w;

    if (state_r == ST_TURN_MUL && !issued_r) begin
      cm_r      <= sum_mag[49:1];
      cneg_r    <= sum_w[50];
      diffneg_r <= diff_w[50];
    end

    if (state_r == ST_TURN_DIV && div_done) q_r <= div_q;

    if ((state_r == ST_FWD || state_r == ST_LAT) && mac_done) term_r <= term_w;

    if (state_r == ST_DONE && (!out_valid_r || out_ready)) begin
      out_r.forward_pos      <= fwd_acc_r;
      out_r.lateral_pos      <= lat_acc_r;
      out_r.heading          <= heading_r;
      out_r.linear_velocity  <= lin_vel_r;
      out_r.angular_velocity <= ang_vel_r;
      out_r.latched_left     <= prev_left_r;
      out_r.latched_right    <= prev_right_r;
      out_r.latched_epoch    <= prev_epoch_r;
      out_r.initialized      <= init_r;
      out_r.finite           <= finite_r;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // finite flag comes back only through a reset item
  a_finite_rise : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(finite_r) |-> $past(state_r == ST_DECODE && reset_path))
    else $error("finite flag set outside a reset item");

  // heading moves only on a reset item or the pose update
  a_heading_step : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$stable(heading_r) |->
      $past(state_r == ST_POSE || state_r == ST_DECODE))
    else $error("heading changed outside pose update");

  // a snapshot is presented only out of the done state
  a_out_from_done : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output raised outside done state");

  // once initialized, stay initialized
  a_init_hold : assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(init_r))
    else $error("initialized flag dropped");

  // at most one shared unit is launched per cycle
  a_one_start : assert property (@(posedge clk) disable iff (!rst_n)
    $countones({mac_start, div_start, cor_start}) <= 1)
    else $error("two units launched together");

endmodule

// ===== bench/tb_differential_drive_odometry.sv =====
// ----------------------------------------------------------------------------
// tb_differential_drive_odometry: self-checking bench for wheel odometry
// Drives encoder items through valid/ready with random idling, predicts every
// snapshot with a fixed-point odometry model kept in the bench, and compares
// each returned snapshot field by field. Configuration changes between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_differential_drive_odometry;
  import ddo_pkg::*;

  localparam int  N_RANDOM    = 430;
  localparam int  DRAIN_WAIT  = 400;
  localparam longint CYCLE_LIMIT = 900000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_index_t cfg_index = CFG_DIST_PER_COUNT;
  logic [31:0] cfg_data = '0;

  differential_drive_odometry DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Odometry state mirrored by the predictor.
  logic [31:0] m_dpc;
  logic [23:0] m_track;
  longint m_fwd, m_lat, m_lin, m_ang, m_left, m_right;
  logic [31:0] m_head, m_epoch, m_time;
  bit m_init, m_no_clamp;

  out_item_t snapshots_due[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  localparam longint MAX48 = 64'sh7FFF_FFFF_FFFF;
  localparam longint MIN48 = -64'sh8000_0000_0000;

  function automatic longint mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Arithmetic shift right, floor semantics.
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wheel_travel(longint delta);
    logic [63:0] p;
    longint d;
    p = 64'(mag_of(delta)) * 64'(m_dpc);
    d = longint'((p >> 16) + ((p >> 15) & 64'd1));
    return delta < 0 ? -d : d;
  endfunction

  // Round-half-away magnitude of a*b / 2^30.
  function automatic longint q30_product(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b[31:0]);
    return longint'(((p >> 30) + ((p >> 29) & 128'd1)) & 128'hFFFF_FFFF_FFFF_FFFF);
  endfunction

  task automatic rotate(input logic [31:0] ang, output longint co, output longint si);
    bit flip;
    longint z, x, y, dx, dy;
    flip = ((ang + 32'h4000_0000) & 32'h8000_0000) != 0;
    if (flip) ang = ang + 32'h8000_0000;
    z = longint'(signed'(ang));
    x = longint'(GAIN_START);
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_angle(5'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_angle(5'(i)));
      end
    end
    co = flip ? -x : x;
    si = flip ? -y : y;
  endtask

  function automatic longint clamp_pos(longint s);
    if (s > MAX48) begin m_no_clamp = 0; return MAX48; end
    if (s < MIN48) begin m_no_clamp = 0; return MIN48; end
    return s;
  endfunction

  function automatic longint pose_term(longint cm, bit cneg, longint f);
    longint t;
    t = q30_product(64'(cm), 64'(mag_of(f)));
    return (cneg != (f < 0)) ? -t : t;
  endfunction

  task automatic integrate_motion(longint dl, longint dr, logic [31:0] elapsed);
    longint l, r, sum, diff, cm, c, co, si;
    bit cneg;
    logic [127:0] q, tw, lv, lq, aq, lim;
    logic [31:0] qmod;
    l = wheel_travel(dl);
    r = wheel_travel(dr);
    sum = l + r;
    diff = r - l;
    cm = mag_of(sum) >> 1;
    cneg = sum < 0;
    c = cneg ? -cm : cm;
    tw = (m_track == 0) ? 128'd1 : 128'(m_track);
    q = 128'(mag_of(diff)) * 128'(ANG_PER_RAD_TURN);
    if (2 * (q % tw) >= tw) q = q / tw + 1;
    else q = q / tw;
    qmod = diff < 0 ? 32'(-q[63:0]) : q[31:0];
    // Midpoint: halve the 64-bit signed increment before wrapping.
    begin
      logic [63:0] q64;
      q64 = diff < 0 ? -q[63:0] : q[63:0];
      rotate(m_head + 32'(q64 >> 1), co, si);
    end
    m_fwd = clamp_pos(m_fwd + pose_term(cm, cneg, co));
    m_lat = clamp_pos(m_lat + pose_term(cm, cneg, si));
    m_head = m_head + qmod;
    if (elapsed == 0) begin
      m_lin = 0; m_ang = 0;
      return;
    end
    lv = 128'(mag_of(c)) * 128'd1000;
    lq = lv / elapsed;
    if (2 * (lv % elapsed) >= 128'(elapsed)) lq++;
    lim = c < 0 ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (lq > lim) begin m_no_clamp = 0; lq = lim; end
    m_lin = c < 0 ? -longint'(lq[63:0]) : longint'(lq[63:0]);
    q = q * 128'd1000;
    aq = q / elapsed;
    if (2 * (q % elapsed) >= 128'(elapsed)) aq++;
    lim = diff < 0 ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (aq > lim) begin m_no_clamp = 0; aq = lim; end
    m_ang = diff < 0 ? -longint'(aq[63:0]) : longint'(aq[63:0]);
  endtask

  function automatic void odometry_reset();
    m_dpc = DPC_RESET; m_track = TRACK_RESET;
    m_fwd = 0; m_lat = 0; m_head = 0; m_lin = 0; m_ang = 0;
    m_left = 0; m_right = 0; m_epoch = 0; m_time = 0;
    m_init = 0; m_no_clamp = 1;
  endfunction

  task automatic predict_snapshot(input in_item_t it, output out_item_t o);
    longint lc, rc;
    lc = longint'(it.left_count);
    rc = longint'(it.right_count);
    if (it.command || !m_init) begin
      m_fwd = 0; m_lat = 0; m_head = 0; m_lin = 0; m_ang = 0;
      m_epoch = it.reset_epoch; m_init = 1; m_no_clamp = 1;
    end else if (it.reset_epoch != m_epoch) begin
      m_epoch = it.reset_epoch;
      integrate_motion(lc, rc, 32'd0);
    end else begin
      integrate_motion(lc - m_left, rc - m_right, it.now_ms - m_time);
    end
    m_left = lc; m_right = rc; m_time = it.now_ms;
    o.forward_pos = m_fwd[47:0];
    o.lateral_pos = m_lat[47:0];
    o.heading = m_head;
    o.linear_velocity = m_lin[31:0];
    o.angular_velocity = m_ang[47:0];
    o.latched_left = m_left[31:0];
    o.latched_right = m_right[31:0];
    o.latched_epoch = m_epoch;
    o.initialized = m_init;
    o.finite = m_no_clamp;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // Sample the result channel at the rising edge; pick the next stall at the falling one.
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n) begin
      cycles <= cycles + 1;
      if (out_valid && out_ready) begin
        if (snapshots_due.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_data.heading), 64'd0);
        end else begin
          w = snapshots_due.pop_front();
          if (out_data.forward_pos !== w.forward_pos)
            report_mismatch("forward_pos", 64'(out_data.forward_pos), 64'(w.forward_pos));
          if (out_data.lateral_pos !== w.lateral_pos)
            report_mismatch("lateral_pos", 64'(out_data.lateral_pos), 64'(w.lateral_pos));
          if (out_data.heading !== w.heading)
            report_mismatch("heading", 64'(out_data.heading), 64'(w.heading));
          if (out_data.linear_velocity !== w.linear_velocity)
            report_mismatch("linear_velocity", 64'(out_data.linear_velocity),
                            64'(w.linear_velocity));
          if (out_data.angular_velocity !== w.angular_velocity)
            report_mismatch("angular_velocity", 64'(out_data.angular_velocity),
                            64'(w.angular_velocity));
          if (out_data.latched_left !== w.latched_left)
            report_mismatch("latched_left", 64'(out_data.latched_left), 64'(w.latched_left));
          if (out_data.latched_right !== w.latched_right)
            report_mismatch("latched_right", 64'(out_data.latched_right),
                            64'(w.latched_right));
          if (out_data.latched_epoch !== w.latched_epoch)
            report_mismatch("latched_epoch", 64'(out_data.latched_epoch),
                            64'(w.latched_epoch));
          if (out_data.initialized !== w.initialized)
            report_mismatch("initialized", 64'(out_data.initialized), 64'(w.initialized));
          if (out_data.finite !== w.finite)
            report_mismatch("finite", 64'(out_data.finite), 64'(w.finite));
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout");
        $display("FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Write one register while the block is idle. Ready is read before the
  // rising edge, where it is stable, and the channel is released before the
  // task returns to the next caller.
  task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
    bit took;
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    took = 1'b0;
    while (!took) begin
      took = cfg_ready;
      @(posedge clk);
      if (!took) @(negedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == CFG_DIST_PER_COUNT) m_dpc = value;
    else m_track = value[23:0];
  endtask

  // Present one item, hold it until accepted, and queue its snapshot.
  task automatic send_item(input in_item_t it, input bit has_typed,
                           input out_item_t typed);
    out_item_t o;
    bit took;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data <= it;
    in_valid <= 1'b1;
    predict_snapshot(it, o);
    if (has_typed && o !== typed)
      report_mismatch("directed row", 64'(o.latched_left), 64'(typed.latched_left));
    snapshots_due.push_back(o);
    took = 1'b0;
    while (!took) begin
      took = in_ready;
      @(posedge clk);
      if (!took) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_results();
    while (snapshots_due.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  typedef struct {
    in_item_t stim;
    bit typed;
    out_item_t want;
  } directed_row_t;

  function automatic in_item_t make_item(bit cmd, int lc, int rc, logic [31:0] ep,
                                         logic [31:0] t);
    in_item_t it;
    it.command = cmd; it.left_count = lc; it.right_count = rc;
    it.reset_epoch = ep; it.now_ms = t;
    return it;
  endfunction

  function automatic out_item_t reset_snapshot(int lc, int rc, logic [31:0] ep);
    out_item_t o;
    o = '0;
    o.latched_left = lc; o.latched_right = rc; o.latched_epoch = ep;
    o.initialized = 1'b1; o.finite = 1'b1;
    return o;
  endfunction

  directed_row_t rows[$];
  in_item_t walk;
  int lc, rc, step;
  logic [31:0] ep, t;

  initial begin
    odometry_reset();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows: first update, reset command, extremes, epoch change,
    // zero elapsed, saturation of velocities.
    rows.push_back('{make_item(0, 100, -100, 32'd7, 32'd10), 1,
                     reset_snapshot(100, -100, 32'd7)});
    rows.push_back('{make_item(0, 200, 100, 32'd7, 32'd20), 0, '0});
    rows.push_back('{make_item(0, 200, 100, 32'd7, 32'd20), 0, '0});
    rows.push_back('{make_item(0, 500, 900, 32'd8, 32'd25), 0, '0});
    rows.push_back('{make_item(1, -5, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
                     reset_snapshot(-5, 5, 32'hFFFF_FFFF)});
    rows.push_back('{make_item(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF,
                               32'd0), 0, '0});
    rows.push_back('{make_item(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
                               32'd1), 0, '0});
    rows.push_back('{make_item(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF,
                               32'd2), 0, '0});
    rows.push_back('{make_item(0, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF,
                               32'd3), 0, '0});
    rows.push_back('{make_item(1, 0, 0, 32'd0, 32'd0), 1, reset_snapshot(0, 0, 32'd0)});
    rows.push_back('{make_item(0, 1, 1, 32'd0, 32'hFFFF_FFFF), 0, '0});
    rows.push_back('{make_item(0, 1, 3, 32'd0, 32'd5), 0, '0});
    rows.push_back('{make_item(1, 0, 0, 32'd0, 32'd0), 1, reset_snapshot(0, 0, 32'd0)});
    foreach (rows[i]) send_item(rows[i].stim, rows[i].typed, rows[i].want);
    drain_results();

    // Largest distance per count, smallest track: drive the accumulators toward clamp.
    write_register(CFG_DIST_PER_COUNT, 32'hFFFF_FFFF);
    write_register(CFG_TRACK_WIDTH, 32'd0);
    send_item(make_item(1, 0, 0, 32'd1, 32'd0), 0, '0);
    send_item(make_item(0, 32'sh7FFF_FFFF, 32'sh8000_0001, 32'd1, 32'd1), 0, '0);
    send_item(make_item(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'd1, 32'd2), 0, '0);
    send_item(make_item(0, 0, 0, 32'd1, 32'd3), 0, '0);
    for (int k = 0; k < 6; k++)
      send_item(make_item(0, (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000,
                          (k % 2) ? 32'sh7FFF_FFFF : 32'sh8000_0000, 32'd1, 32'(4 + k)),
                0, '0);
    // Hold off until every snapshot is back.
    drain_results();

    // Random phases: settings and idling change between phases.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_register(CFG_DIST_PER_COUNT, DPC_RESET);
                 write_register(CFG_TRACK_WIDTH, 32'(TRACK_RESET)); end
        1: begin write_register(CFG_DIST_PER_COUNT, 32'd1);
                 write_register(CFG_TRACK_WIDTH, 32'h00FF_FFFF); end
        2: begin write_register(CFG_DIST_PER_COUNT, $urandom);
                 write_register(CFG_TRACK_WIDTH, 32'($urandom_range(1, 24'hFFFFFF))); end
        default: begin write_register(CFG_DIST_PER_COUNT, $urandom_range(1, 1 << 26));
                 write_register(CFG_TRACK_WIDTH, 32'($urandom_range(1000, 90000))); end
      endcase
      send_idle_pct = (ph == 1 || ph == 3) ? 73 : (ph == 4 ? 7 : 0);
      recv_stall_pct = (ph == 2 || ph == 3) ? 73 : (ph == 4 ? 7 : 0);
      lc = int'($urandom); rc = int'($urandom); ep = $urandom; t = $urandom;
      send_item(make_item(1, lc, rc, ep, t), 0, '0);
      for (int n = 0; n < N_RANDOM / 5; n++) begin
        step = $urandom_range(99);
        if (step < 80) begin
          // Plausible motion: small deltas, advancing time.
          lc += $signed($urandom_range(0, 4000)) - 2000;
          rc += $signed($urandom_range(0, 4000)) - 2000;
          t += $urandom_range(0, 50);
        end else if (step < 88) begin
          lc = int'($urandom); rc = int'($urandom); t = $urandom;
        end else if (step < 94) begin
          ep = $urandom; lc = $urandom_range(0, 3000); rc = $urandom_range(0, 3000);
        end else begin
          send_item(make_item(1, lc, rc, ep, t), 0, '0);
          continue;
        end
        walk = make_item(0, lc, rc, ep, t);
        send_item(walk, 0, '0);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_mac.sv
hw/rtl/ddo_div.sv
hw/rtl/ddo_cordic.sv
hw/rtl/differential_drive_odometry.sv
bench/tb_differential_drive_odometry.sv
